// ----- sv/swpc_pkg.sv -----
// ----------------------------------------------------------------------------
// swpc_pkg
// shared types and constants of the servo window position controller
// ----------------------------------------------------------------------------
package swpc_pkg;

	localparam int unsigned STALL_LIMIT = 600;
	// the timer saturates one above the limit
	localparam int unsigned TIMER_W     = $clog2(STALL_LIMIT + 2);

	localparam int unsigned SAMPLE_W    = 8;
	localparam int unsigned SEL_W       = 2;
	localparam int unsigned NUM_WIN     = 4;
	localparam int unsigned PHASE_W     = 3;
	localparam int unsigned CFG_IDX_W   = 8;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [PHASE_W-1:0] PHASE_HIGH_END = 3'd4;
	localparam logic [PHASE_W-1:0] PHASE_DECIDE   = 3'd6;
	localparam logic [PHASE_W-1:0] PHASE_LAST     = 3'd7;
	localparam logic [PHASE_W-1:0] PHASE_RESTART  = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_FIRST    = 3'd1;

	typedef enum logic [1:0] {
		DRIVE_OFF   = 2'd0,
		DRIVE_RIGHT = 2'd1,
		DRIVE_LEFT  = 2'd2
	} drive_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SEL_W-1:0]    sel_t;

	// one window as seen by the decision logic
	typedef struct packed {
		sample_t low;
		sample_t high;
	} window_t;

	// result item, last field in the lowest bits
	typedef struct packed {
		logic   motor_stuck;
		logic   target_reached;
		logic   sample_taken;
		logic   convert_start;
		drive_t motor_drive;
	} result_t;

	localparam sample_t LOW_RESET  [NUM_WIN] = '{8'd0, 8'd8, 8'd35, 8'd80};
	localparam sample_t HIGH_RESET [NUM_WIN] = '{8'd2, 8'd12, 8'd55, 8'd110};

endpackage

// ----- sv/servo_window_position_controller_top.sv -----
// a result appears in the output register in the cycle after its tick is accepted
// throughput: one tick per clock while m_tready is high; the output register refills in the cycle it drains
// per-tick work is a single pass of compare and counter logic in swpc_core
// reset (arst_n low, asynchronous): phase 0, timer 0, motor off, start line low,
// stuck flag clear, window bounds back to their defaults, output empty
// ----------------------------------------------------------------------------
// servo_window_position_controller_top
// seven-phase converter sequencer with window based motor drive and stall latch
// ----------------------------------------------------------------------------
module servo_window_position_controller_top
	import swpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// tick input
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [7:0] position_sample, [9:8] target_select, [15:10] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// result output
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] motor_drive, [2] convert_start, [3] sample_taken,
	// [4] target_reached, [5] motor_stuck, [7:6] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// bound register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	sample_t sample;
	sel_t    sel;
	window_t window;
	result_t result;
	result_t result_q;
	logic    out_valid_q;
	logic    accept;

	// unpack the tick transfer
	assign sample = s_tdata[SAMPLE_W-1:0];
	assign sel    = s_tdata[SAMPLE_W+SEL_W-1:SAMPLE_W];

	// take a tick whenever the output register is empty or draining
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	swpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.sel      (sel),
		.window   (window)
	);

	// core state advances on the accepting edge unless the stall latch is set, the result is captured alongside
	swpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.sample (sample),
		.sel    (sel),
		.window (window),
		.result (result)
	);

	// output register, control reset only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_q};

endmodule

// ----- sv/swpc_cfg.sv -----
// ----------------------------------------------------------------------------
// swpc_cfg
// window bound registers with write port and window selection
// ----------------------------------------------------------------------------
module swpc_cfg
	import swpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  sel_t                  sel,
	output window_t               window
);

	sample_t low_q  [NUM_WIN];
	sample_t high_q [NUM_WIN];

	logic in_range;
	sel_t wr_win;

	// indexes past the last high bound are dropped
	assign in_range = (wr_index[CFG_IDX_W-1:SEL_W+1] == '0);
	assign wr_win   = wr_index[SEL_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIN; i++) begin
				low_q[i]  <= LOW_RESET[i];
				high_q[i] <= HIGH_RESET[i];
			end
		end else if (wr_en && in_range) begin
			if (wr_index[0]) begin
				high_q[wr_win] <= sample_t'(wr_data);
			end else begin
				low_q[wr_win] <= sample_t'(wr_data);
			end
		end
	end

	assign window.low  = low_q[sel];
	assign window.high = high_q[sel];

endmodule

// ----- sv/swpc_core.sv -----
// ----------------------------------------------------------------------------
// swpc_core
// phase sequencer, window decision and stall supervision for one tick
// ----------------------------------------------------------------------------
module swpc_core
	import swpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t sample,
	input  sel_t    sel,
	input  window_t window,
	output result_t result
);

	logic [PHASE_W-1:0] phase_q, phase_d, phase_inc;
	logic [TIMER_W-1:0] timer_q, timer_d;
	sel_t               held_sel_q;
	drive_t             drive_q, drive_d;
	logic               conv_q, conv_d;
	logic               stuck_q, stuck_d;
	logic               taken, reached, in_window;

	assign phase_inc = phase_q + PHASE_W'(1);
	assign in_window = (sample > window.low) && (sample <= window.high);

	always_comb begin
		phase_d = phase_inc;
		timer_d = timer_q;
		drive_d = drive_q;
		conv_d  = conv_q;
		stuck_d = stuck_q;
		taken   = 1'b0;
		reached = 1'b0;
		if (!stuck_q) begin
			if (timer_q <= TIMER_W'(STALL_LIMIT)) begin
				timer_d = timer_q + TIMER_W'(1);
			end
			if (phase_inc >= PHASE_FIRST && phase_inc <= PHASE_HIGH_END) begin
				conv_d = 1'b1;
			end else if (phase_inc == PHASE_LAST || phase_inc == PHASE_RESTART) begin
				phase_d = PHASE_RESTART;
				taken   = 1'b1;
				conv_d  = 1'b0;
			end else begin
				taken = 1'b1;
			end
			if (sel != held_sel_q) begin
				timer_d = '0;
			end
			if (phase_d == PHASE_DECIDE) begin
				if (in_window) begin
					reached = 1'b1;
					timer_d = '0;
					drive_d = DRIVE_OFF;
				end else if (sample <= window.low) begin
					drive_d = DRIVE_RIGHT;
				end else begin
					drive_d = DRIVE_LEFT;
				end
			end
			if (timer_d > TIMER_W'(STALL_LIMIT)) begin
				stuck_d = 1'b1;
				drive_d = DRIVE_OFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PHASE_RESTART;
			timer_q    <= '0;
			held_sel_q <= '0;
			drive_q    <= DRIVE_OFF;
			conv_q     <= 1'b0;
			stuck_q    <= 1'b0;
		end else if (step && !stuck_q) begin
			phase_q    <= phase_d;
			timer_q    <= timer_d;
			held_sel_q <= sel;
			drive_q    <= drive_d;
			conv_q     <= conv_d;
			stuck_q    <= stuck_d;
		end
	end

	// halted ticks report only the line level and the stuck flag
	assign result.motor_drive    = drive_d;
	assign result.convert_start  = conv_d;
	assign result.sample_taken   = taken;
	assign result.target_reached = reached;
	assign result.motor_stuck    = stuck_q | stuck_d;

endmodule
